// ===== hw/rtl/rdsc_pkg.sv =====
// shared types, constants and helpers of the radix digit string converter
package rdsc_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int RADIX_WIDTH         = 6;
   localparam int DIGIT_WIDTH         = 6;
   localparam int CHAR_WIDTH          = 7;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;

   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO    = 7'd48;
   localparam logic [CHAR_WIDTH-1:0]  ALPHA_OFFSET  = 7'd87;
   localparam logic [DIGIT_WIDTH-1:0] DECIMAL_LIMIT = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_EMIT,
      ST_ERROR
   } rdsc_state_type;

   typedef struct packed {
      logic load;
      logic start;
   } rdsc_div_ctl_type;

   typedef struct packed {
      logic done;
      logic quo_zero;
   } rdsc_div_stat_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d < DECIMAL_LIMIT) begin
         return ASCII_ZERO + d_ext;
      end
      return d_ext + ALPHA_OFFSET;
   endfunction

   function automatic logic radix_is_bad(input logic [RADIX_WIDTH-1:0] r);
      return (r < RADIX_MIN) || (r > RADIX_MAX);
   endfunction

endpackage

// ===== hw/rtl/rdsc_channels.sv =====
// request and response channel interfaces of the radix digit string converter
interface rdsc_req_if
   import rdsc_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdsc_rsp_if
   import rdsc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] digit_char;
   logic                  last;
   logic                  bad_radix;

   modport source (output valid, output digit_char, output last, output bad_radix, input ready);
   modport sink   (input valid, input digit_char, input last, input bad_radix, output ready);
endinterface

// ===== hw/rtl/radix_digit_string_converter_unit.sv =====
// radix digit string converter top level: control sequencer, radix register, response register
// Converts each accepted value to ASCII text in the base held by the radix register (2 to 36,
// reset 10), one response beat per character, most significant digit first, with last set on
// the final character; a zero value gives a single '0'. A radix outside 2..36 gives one beat
// with bad_radix and last set and digit_char zero. Digits come from a bit-serial divider that
// produces one quotient bit per cycle; the digits are then read back from the digit buffer
// through its registered read port, one character at a time. A new value is accepted only
// after the last character has entered the response register. The radix register is written
// through csr_wr_en and csr_wr_data; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module radix_digit_string_converter_unit
   import rdsc_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [RADIX_WIDTH-1:0] csr_wr_data,
   rdsc_req_if.sink               req_chan,
   rdsc_rsp_if.source             rsp_chan
);

   localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   rdsc_state_type         state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          ptr_ff, ptr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   rdsc_div_ctl_type       div_ctl;
   rdsc_div_stat_type      div_stat;
   logic [DIGIT_WIDTH-1:0] div_digit;
   logic                   mem_wr_en;
   logic [DIGIT_WIDTH-1:0] mem_rd_data;
   logic                   slot_free;
   logic                   accept;

   rdsc_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .value (req_chan.value),
      .radix (radix_ff),
      .stat  (div_stat),
      .digit (div_digit)
   );

   rdsc_digit_stack #(
      .DEPTH (VALUE_WIDTH)
   ) u_digit_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (div_digit),
      .rd_addr (ptr_ff),
      .rd_data (mem_rd_data)
   );

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      div_ctl       = '0;
      mem_wr_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (radix_is_bad(radix_ff)) begin
                  state_in = ST_ERROR;
               end else begin
                  div_ctl.load = 1'b1;
                  count_in     = '0;
                  state_in     = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               if (div_stat.quo_zero) begin
                  ptr_in   = count_ff[AW-1:0];
                  state_in = ST_READ;
               end else begin
                  div_ctl.start = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_ascii(mem_rd_data);
               rsp_last_in  = (ptr_ff == '0);
               rsp_bad_in   = 1'b0;
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      ptr_ff      <= ptr_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.digit_char = rsp_char_ff;
   assign rsp_chan.last       = rsp_last_ff;
   assign rsp_chan.bad_radix  = rsp_bad_ff;

endmodule

// ===== hw/rtl/rdsc_divider.sv =====
// bit-serial restoring divider, one quotient bit per cycle, yields one digit per pass
module rdsc_divider
   import rdsc_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rdsc_div_ctl_type        ctl,
   input  logic [VALUE_WIDTH-1:0]  value,
   input  logic [RADIX_WIDTH-1:0]  radix,
   output rdsc_div_stat_type       stat,
   output logic [DIGIT_WIDTH-1:0]  digit
);

   localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [BW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIGIT_WIDTH:0]   trial;
   logic [DIGIT_WIDTH:0]   radix_ext;
   logic                   fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      radix_ext = {1'b0, radix};
      fits      = trial >= radix_ext;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.load || ctl.start) begin
         if (ctl.load) begin
            quo_in = value;
         end
         rem_in  = '0;
         cnt_in  = BW'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? DIGIT_WIDTH'(trial - radix_ext) : trial[DIGIT_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.quo_zero = (quo_ff == '0);
   assign digit         = rem_ff;

endmodule

// ===== hw/rtl/rdsc_digit_stack.sv =====
// digit buffer memory, one write port and one registered read port
module rdsc_digit_stack
   import rdsc_pkg::*;
#(
   parameter int DEPTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DIGIT_WIDTH-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DIGIT_WIDTH-1:0]       rd_data
);

   logic [DIGIT_WIDTH-1:0] mem [DEPTH];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rdsc_checker.sv =====
// port-level checker of the radix digit string converter and its bind
module rdsc_port_checker
   import rdsc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CHAR_WIDTH-1:0] rsp_digit_char,
   input logic                  rsp_last,
   input logic                  rsp_bad_radix
);

   rsp_hold_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last)
         && $stable(rsp_bad_radix))
      else $error("response beat changed while stalled");

   bad_radix_shape_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radix |-> rsp_last && (rsp_digit_char == '0))
      else $error("bad radix beat is not a single zero character");

   char_range_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_radix |->
         (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) ||
         (rsp_digit_char >= 7'd97 && rsp_digit_char <= 7'd122))
      else $error("digit character outside 0-9 and a-z");

   reset_idle_check: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind radix_digit_string_converter_unit rdsc_port_checker u_rdsc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_digit_char (rsp_chan.digit_char),
   .rsp_last       (rsp_chan.last),
   .rsp_bad_radix  (rsp_chan.bad_radix)
);

// ===== test/rdsc_checker.sv =====
// checker: predicts the characters of every accepted value and compares them with the response beats
module rdsc_checker
   import rdsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [RADIX_WIDTH-1:0] csr_wr_data,
   rdsc_req_if                    req_chan,
   rdsc_rsp_if                    rsp_chan,
   output int                     fail_count,
   output int                     pending_count,
   output int                     char_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = VALUE_WIDTH_DEFAULT;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last;
      logic                  bad_radix;
   } char_beat_type;

   char_beat_type          pending_chars[$];
   logic [RADIX_WIDTH-1:0] radix_model;

   // digits come out least significant first, the string goes most significant first
   function automatic void spell_value(input logic [VW-1:0] value);
      logic [DIGIT_WIDTH-1:0] digits[VW];
      logic [VW-1:0]          quot;
      logic [VW-1:0]          base;
      int                     n;
      char_beat_type          beat;
      if (radix_model < RADIX_MIN || radix_model > RADIX_MAX) begin
         beat.digit_char = '0;
         beat.last       = 1'b1;
         beat.bad_radix  = 1'b1;
         pending_chars.push_back(beat);
         return;
      end
      base = VW'(radix_model);
      quot = value;
      n    = 0;
      do begin
         digits[n] = DIGIT_WIDTH'(quot % base);
         n++;
         quot = quot / base;
      end while (quot != 0 && n < VW);
      for (int k = n - 1; k >= 0; k--) begin
         if (digits[k] < DECIMAL_LIMIT) begin
            beat.digit_char = ASCII_ZERO + CHAR_WIDTH'(digits[k]);
         end else begin
            beat.digit_char = CHAR_WIDTH'(digits[k]) + ALPHA_OFFSET;
         end
         beat.last      = (k == 0);
         beat.bad_radix = 1'b0;
         pending_chars.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      char_beat_type want;
      if (reset) begin
         radix_model = RADIX_RESET;
         pending_chars.delete();
         fail_count = 0;
         char_count = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected beat: digit_char %0d, last %0b, bad_radix %0b",
                      rsp_chan.digit_char, rsp_chan.last, rsp_chan.bad_radix);
               fail_count++;
            end else begin
               want = pending_chars.pop_front();
               char_count++;
               if (rsp_chan.digit_char !== want.digit_char) begin
                  $error("digit_char: expected %0d, got %0d", want.digit_char,
                         rsp_chan.digit_char);
                  fail_count++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_chan.last);
                  fail_count++;
               end
               if (rsp_chan.bad_radix !== want.bad_radix) begin
                  $error("bad_radix: expected %0b, got %0b", want.bad_radix,
                         rsp_chan.bad_radix);
                  fail_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            spell_value(req_chan.value);
         end
         if (csr_wr_en) begin
            radix_model = csr_wr_data;
         end
      end
      pending_count = pending_chars.size();
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top: clock, reset, stimulus and verdict for the radix digit string converter
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rdsc_pkg::*;

   localparam int IDLE_LIMIT      = 5000;
   localparam int SETTLE_CYCLES   = 80;
   localparam int RANDOM_SEGMENTS = 15;
   localparam int SEGMENT_VALUES  = 13;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [RADIX_WIDTH-1:0] csr_wr_data;
   logic [RADIX_WIDTH-1:0] radix_now = RADIX_RESET;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles   = 0;
   int value_count   = 0;
   int bad_count     = 0;
   int setting_count = 0;
   int fail_count;
   int pending_count;
   int char_count;

   rdsc_req_if req_chan ();
   rdsc_rsp_if rsp_chan ();

   radix_digit_string_converter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   rdsc_checker chk (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .char_count    (char_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // valid stays high from one beat to the next unless the sender idles
   task automatic send_value(input logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= v;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      value_count++;
      if (radix_now < RADIX_MIN || radix_now > RADIX_MAX) begin
         bad_count++;
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic set_radix(input logic [RADIX_WIDTH-1:0] r);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      radix_now = r;
      setting_count++;
   endtask

   initial begin
      logic [31:0] v;
      logic [63:0] p;
      int          k;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 54;

      // reset radix, then the extremes of base and value
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'hFFFF_FFFF);
      send_value(32'd1234567890);
      set_radix(6'd2);
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
      set_radix(RADIX_MAX);
      send_value(32'd35);
      send_value(32'd36);
      send_value(32'hFFFF_FFFF);
      set_radix(6'd16);
      send_value(32'hDEAD_BEEF);
      send_value(32'h0000_000F);
      set_radix(6'd0);
      send_value(32'd5);
      set_radix(6'd1);
      send_value(32'd0);
      set_radix(6'd37);
      send_value(32'h0000_FFFF);
      set_radix(6'd63);
      send_value(32'hFFFF_FFFF);
      set_radix(6'd3);
      send_value(32'hFFFF_FFFF);

      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         if (seg == RANDOM_SEGMENTS / 3) begin
            send_idle_pct = 54;
            recv_idle_pct = 32;
         end else if (seg == 2 * RANDOM_SEGMENTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(9))
            0:       set_radix(RADIX_WIDTH'($urandom_range(1)));
            1:       set_radix(RADIX_WIDTH'($urandom_range(63, 37)));
            2:       set_radix(RADIX_MIN);
            3:       set_radix(RADIX_MAX);
            default: set_radix(RADIX_WIDTH'($urandom_range(36, 2)));
         endcase
         for (int i = 0; i < SEGMENT_VALUES; i++) begin
            case ($urandom_range(7))
               0: v = '0;
               1: v = '1;
               2, 3: begin
                  // values next to a power of the radix, where the digit count changes
                  p = 64'd1;
                  k = $urandom_range(31, 1);
                  repeat (k) begin
                     if (p * radix_now <= 64'hFFFF_FFFF) begin
                        p = p * radix_now;
                     end
                  end
                  v = p[31:0] - 32'($urandom_range(1));
               end
               4:       v = 32'($urandom_range(999));
               default: v = $urandom;
            endcase
            send_value(v);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("summary: %0d values over %0d radix settings, %0d of them with an invalid radix",
               value_count, setting_count, bad_count);
      $display("summary: %0d characters checked under three sender/receiver stall mixes",
               char_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
